/* design/life_generation_step_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros shared by the life generation step block.
// ----------------------------------------------------------------------------
`ifndef LIFE_GENERATION_STEP_MACROS_SVH
`define LIFE_GENERATION_STEP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LGS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LGS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/lgs_pkg.sv */
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared constants and payload types of the life generation step block.
// ----------------------------------------------------------------------------
package lgs_pkg;

    // Grid size. Rows travel in a fixed 64-bit field; only COLUMNS bits are used.
    localparam int COLUMNS   = 64;
    localparam int ROWS      = 64;
    localparam int ROW_BITS  = 64;
    localparam int ROW_NUM_W = 6;

    // Row store addressing and counters.
    localparam int ROW_AW = $clog2(ROWS);
    localparam int CNT_W  = $clog2(ROWS + 1);
    localparam int KCNT_W = $clog2(ROWS + 2);

    // Input transaction payload.
    typedef struct packed {
        logic [ROW_BITS-1:0] row_cells;
        logic                last_row;
    } in_t;

    // Result transaction payload.
    typedef struct packed {
        logic [ROW_BITS-1:0]  next_cells;
        logic [ROW_NUM_W-1:0] row_number;
        logic                 final_row;
        logic                 rows_dropped;
    } out_t;

    // Three-row neighborhood window around the row being computed.
    typedef struct packed {
        logic [ROW_BITS-1:0] up;
        logic [ROW_BITS-1:0] mid;
        logic [ROW_BITS-1:0] down;
    } window_t;

endpackage

/* design/life_generation_step.sv */
// ----------------------------------------------------------------------------
// life_generation_step
// Rows are accepted one per cycle while the block is loading. Each result takes
// a read, a window shift and an output load, paced by the single read port of
// the row store; the output load waits while the output register is full and
// not being taken. Synchronous active-low reset clears control
// state and the wrap register; the row store is not cleared.
// ----------------------------------------------------------------------------
`include "life_generation_step_macros.svh"

module life_generation_step (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  lgs_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output lgs_pkg::out_t m_data,
    input  logic          cfg_wr_en,
    input  logic          cfg_wr_data
);

    localparam int ROWS   = lgs_pkg::ROWS;
    localparam int ROW_AW = lgs_pkg::ROW_AW;
    localparam int CNT_W  = lgs_pkg::CNT_W;
    localparam int KCNT_W = lgs_pkg::KCNT_W;
    localparam int RNW    = lgs_pkg::ROW_NUM_W;
    localparam int NBIT   = lgs_pkg::ROW_BITS;

    typedef enum logic [1:0] {
        S_LOAD,
        S_READ,
        S_SHIFT,
        S_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    rows_loaded_reg, rows_loaded_next;
    logic                overflow_seen_reg, overflow_next;
    logic [KCNT_W-1:0]   k_reg, k_next;
    logic [ROW_AW-1:0]   r_reg, r_next;
    lgs_pkg::window_t    window_reg, window_next;
    logic                m_valid_reg, m_valid_next;
    lgs_pkg::out_t       m_data_reg, m_data_next;
    logic                edge_wrap_reg;

    logic [NBIT-1:0]     row_mem [ROWS];
    logic [NBIT-1:0]     rd_data_reg;
    logic                wr_en;
    logic [ROW_AW-1:0]   rd_addr;
    logic [NBIT-1:0]     next_row;

    logic [KCNT_W-1:0]   height_k;
    logic [KCNT_W-1:0]   row_sel;
    logic                sel_in_grid;
    logic                fetch_live;
    logic [KCNT_W-1:0]   fetch_addr;
    logic                last_emit;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_wrap_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            edge_wrap_reg <= cfg_wr_data;
        end
    end

    // Row store: one write port during load, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            row_mem[rows_loaded_reg[ROW_AW-1:0]] <= s_data.row_cells;
        end
        rd_data_reg <= row_mem[rd_addr];
    end

    // Fetch k brings row k-1 into the window: the row above the top for k of
    // zero, and rows past the bottom wrap to the top or read as dead.
    assign height_k    = KCNT_W'(rows_loaded_reg);
    assign row_sel     = k_reg - KCNT_W'(1);
    assign sel_in_grid = row_sel < height_k;
    always_comb begin
        if (k_reg == '0) begin
            fetch_addr = height_k - KCNT_W'(1);
            fetch_live = edge_wrap_reg;
        end else if (sel_in_grid) begin
            fetch_addr = row_sel;
            fetch_live = 1'b1;
        end else begin
            fetch_addr = row_sel - height_k;
            fetch_live = edge_wrap_reg;
        end
    end
    assign rd_addr = fetch_addr[ROW_AW-1:0];

    // Column lanes and merge over the current window.
    lgs_row_unit u_row_unit (
        .window    (window_reg),
        .edge_wrap (edge_wrap_reg),
        .next_row  (next_row)
    );

    assign last_emit = (CNT_W'(r_reg) + CNT_W'(1)) == rows_loaded_reg;

    // Sequencer next-state logic.
    always_comb begin
        state_next       = state_reg;
        rows_loaded_next = rows_loaded_reg;
        overflow_next    = overflow_seen_reg;
        k_next           = k_reg;
        r_next           = r_reg;
        window_next      = window_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;
        wr_en            = 1'b0;

        // The output register empties when its transaction completes.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_LOAD: begin
                if (s_valid) begin
                    if (rows_loaded_reg < CNT_W'(ROWS)) begin
                        wr_en            = 1'b1;
                        rows_loaded_next = rows_loaded_reg + CNT_W'(1);
                    end else begin
                        overflow_next = 1'b1;
                    end
                    if (s_data.last_row) begin
                        k_next     = '0;
                        r_next     = '0;
                        state_next = S_READ;
                    end
                end
            end
            S_READ: begin
                state_next = S_SHIFT;
            end
            S_SHIFT: begin
                window_next.up   = window_reg.mid;
                window_next.mid  = window_reg.down;
                window_next.down = fetch_live ? rd_data_reg : '0;
                k_next           = k_reg + KCNT_W'(1);
                state_next       = (k_reg >= KCNT_W'(2)) ? S_EMIT : S_READ;
            end
            S_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    m_data_next.next_cells   = next_row;
                    m_data_next.row_number   = RNW'(r_reg);
                    m_data_next.final_row    = last_emit;
                    m_data_next.rows_dropped = overflow_seen_reg;
                    if (last_emit) begin
                        rows_loaded_next = '0;
                        overflow_next    = 1'b0;
                        state_next       = S_LOAD;
                    end else begin
                        r_next     = r_reg + ROW_AW'(1);
                        state_next = S_READ;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_LOAD;
            rows_loaded_reg   <= '0;
            overflow_seen_reg <= 1'b0;
            k_reg             <= '0;
            r_reg             <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            rows_loaded_reg   <= rows_loaded_next;
            overflow_seen_reg <= overflow_next;
            k_reg             <= k_next;
            r_reg             <= r_next;
            m_valid_reg       <= m_valid_next;
        end
        window_reg <= window_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == S_LOAD);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The row count never exceeds the store depth.
    `LGS_ASSERT_NOW(a_rows_bounded, aclk, aresetn, 1'b1, rows_loaded_reg <= CNT_W'(ROWS), "row count exceeds store depth")
    // A dropped row is only possible with a full store.
    `LGS_ASSERT_NOW(a_overflow_full, aclk, aresetn, overflow_seen_reg, rows_loaded_reg == CNT_W'(ROWS), "overflow flagged with a store that is not full")
    // While emitting, the window holds the rows around the current row.
    `LGS_ASSERT_NOW(a_window_lead, aclk, aresetn, state_reg == S_EMIT, k_reg == KCNT_W'(r_reg) + KCNT_W'(3), "window out of step with emitted row")
    // Emission never runs over an empty grid.
    `LGS_ASSERT_NOW(a_grid_nonempty, aclk, aresetn, state_reg != S_LOAD, rows_loaded_reg != '0, "emission with no stored rows")
    // A window shift is followed by another read or by an emit.
    `LGS_ASSERT_NEXT(a_shift_order, aclk, aresetn, state_reg == S_SHIFT, state_reg == S_READ || state_reg == S_EMIT, "bad state after window shift")

endmodule

/* design/lgs_cell_lane.sv */
// ----------------------------------------------------------------------------
// lgs_cell_lane
// Applies the B3/S23 rule to one cell from its 3x3 neighborhood.
// ----------------------------------------------------------------------------
module lgs_cell_lane (
    input  logic [2:0] up_w,
    input  logic [2:0] mid_w,
    input  logic [2:0] down_w,
    output logic       next_cell
);

    logic [3:0] live_count;

    // Count the eight neighbors; the center cell itself is excluded.
    assign live_count = 4'(up_w[0]) + 4'(up_w[1]) + 4'(up_w[2])
                      + 4'(mid_w[0]) + 4'(mid_w[2])
                      + 4'(down_w[0]) + 4'(down_w[1]) + 4'(down_w[2]);

    // Born with exactly three neighbors, survives with two or three.
    assign next_cell = (live_count == 4'd3) || (mid_w[1] && (live_count == 4'd2));

endmodule

/* design/lgs_row_unit.sv */
// ----------------------------------------------------------------------------
// lgs_row_unit
// One lane per column computes the next state; the lane outputs merge into
// the next-generation row. Columns past the grid width read as zero.
// ----------------------------------------------------------------------------
module lgs_row_unit (
    input  lgs_pkg::window_t                 window,
    input  logic                             edge_wrap,
    output logic [lgs_pkg::ROW_BITS-1:0]     next_row
);

    localparam int NCOL = lgs_pkg::COLUMNS;
    localparam int NBIT = lgs_pkg::ROW_BITS;

    for (genvar c = 0; c < NBIT; c++) begin : g_col
        if (c < NCOL) begin : g_lane
            // Neighbor columns, wrapping at the left and right edges.
            localparam int LI = (c == 0) ? NCOL - 1 : c - 1;
            localparam int RI = (c == NCOL - 1) ? 0 : c + 1;
            localparam bit LEDGE = (c == 0);
            localparam bit REDGE = (c == NCOL - 1);

            logic       left_ok;
            logic       right_ok;
            logic [2:0] up_w;
            logic [2:0] mid_w;
            logic [2:0] down_w;

            // Outside columns are dead unless wrapping is enabled.
            assign left_ok  = LEDGE ? edge_wrap : 1'b1;
            assign right_ok = REDGE ? edge_wrap : 1'b1;

            assign up_w   = {window.up[RI] & right_ok, window.up[c],
                             window.up[LI] & left_ok};
            assign mid_w  = {window.mid[RI] & right_ok, window.mid[c],
                             window.mid[LI] & left_ok};
            assign down_w = {window.down[RI] & right_ok, window.down[c],
                             window.down[LI] & left_ok};

            lgs_cell_lane u_lane (
                .up_w      (up_w),
                .mid_w     (mid_w),
                .down_w    (down_w),
                .next_cell (next_row[c])
            );
        end else begin : g_pad
            // Bits beyond the grid width are always dead.
            assign next_row[c] = 1'b0;
        end
    end

endmodule
